// ----- hdl/luhn_pkg.sv -----
// Package for the card number Luhn validator.
// Holds widths, verdict and register codes, controller states and the
// command and status structs shared by the controller and datapath.
`default_nettype none

package luhn_pkg;

  localparam int CardW     = 63;
  localparam int NumDigits = 19;
  localparam int BcdW      = 4 * NumDigits;
  localparam int LenW      = 5;
  localparam int CntW      = 6;
  localparam int IdxW      = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 5;

  localparam logic [CntW-1:0] ConvLast = CntW'(CardW - 1);
  localparam logic [CntW-1:0] ScanLast = CntW'(NumDigits - 1);

  localparam logic [LenW-1:0] MinDigitsReset = 5'd13;
  localparam logic [LenW-1:0] MaxDigitsReset = 5'd16;

  localparam logic [CfgIdxW-1:0] RegMinDigits = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxDigits = 2'd1;

  localparam logic [1:0] VerdictOk       = 2'd0;
  localparam logic [1:0] VerdictBadLen   = 2'd1;
  localparam logic [1:0] VerdictBadPref  = 2'd2;
  localparam logic [1:0] VerdictChecksum = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            load;
    logic            conv_step;
    logic            scan_step;
    logic            res_load;
    logic [IdxW-1:0] scan_idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ----- hdl/luhn_ifs.sv -----
// Channel interfaces of the card number Luhn validator.
// Depends on luhn_pkg for the payload widths.
`default_nettype none

interface luhn_in_if import luhn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CardW-1:0] card_number;
  modport source (output valid, output card_number, input ready);
  modport sink (input valid, input card_number, output ready);
endinterface

interface luhn_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [1:0] verdict;
  modport source (output valid, output valid_res, output verdict, input ready);
  modport sink (input valid, input valid_res, input verdict, output ready);
endinterface

interface luhn_cfg_if import luhn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/luhn_ctrl.sv -----
// Controller of the card number Luhn validator.
// Sequences conversion, digit scan and result hand-off; uses luhn_pkg.
`default_nettype none

module luhn_ctrl import luhn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t          state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.scan_idx  = cnt[IdxW-1:0];
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (cnt == ConvLast) begin
          cnt_next   = '0;
          state_next = ST_SCAN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (cnt == ScanLast) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/luhn_dp.sv -----
// Datapath of the card number Luhn validator: limit registers, binary to
// decimal converter, digit scanner and result register. Uses luhn_pkg.
`default_nettype none

module luhn_dp import luhn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  input  wire logic [CardW-1:0] card_number,
  luhn_cfg_if.sink              cfg,
  luhn_out_if.source            result,
  output stat_t                 stat
);

  logic [LenW-1:0]  min_digits, max_digits;
  logic [CardW-1:0] bin;
  logic [BcdW-1:0]  bcd, bcd_adj;
  logic [LenW-1:0]  len;
  logic [3:0]       top, second, prev, sum;
  logic             out_valid;
  logic             out_valid_res;
  logic [1:0]       out_verdict;

  logic [3:0] digit, contrib, sum_next;
  logic [4:0] dbl, sum_raw;
  logic       pref;
  logic [1:0] verdict_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_digits <= MinDigitsReset;
      max_digits <= MaxDigitsReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegMinDigits: min_digits <= cfg.data;
        RegMaxDigits: max_digits <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign digit   = bcd[3:0];
  assign dbl     = {digit, 1'b0};
  assign contrib = cmd.scan_idx[0] ? ((dbl < 5'd10) ? dbl[3:0] : 4'(dbl - 5'd9)) : digit;
  assign sum_raw = {1'b0, sum} + {1'b0, contrib};
  assign sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin    <= card_number;
      bcd    <= '0;
      len    <= '0;
      top    <= '0;
      second <= '0;
      prev   <= '0;
      sum    <= '0;
    end else if (cmd.conv_step) begin
      bin <= {bin[CardW-2:0], 1'b0};
      bcd <= {bcd_adj[BcdW-2:0], bin[CardW-1]};
    end else if (cmd.scan_step) begin
      bcd  <= {4'd0, bcd[BcdW-1:4]};
      prev <= digit;
      sum  <= sum_next;
      if (digit != 4'd0) begin
        len    <= cmd.scan_idx + 1'b1;
        top    <= digit;
        second <= prev;
      end
    end
  end

  always_comb begin
    pref = 1'b0;
    if (len >= 5'd1 && (top == 4'd4 || top == 4'd5 || top == 4'd6)) begin
      pref = 1'b1;
    end
    if (len >= 5'd2 && top == 4'd3 && second == 4'd7) begin
      pref = 1'b1;
    end
    if (len < min_digits || len > max_digits) begin
      verdict_next = VerdictBadLen;
    end else if (!pref) begin
      verdict_next = VerdictBadPref;
    end else if (sum != 4'd0) begin
      verdict_next = VerdictChecksum;
    end else begin
      verdict_next = VerdictOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_verdict   <= verdict_next;
      out_valid_res <= (verdict_next == VerdictOk);
    end
  end

  assign result.valid     = out_valid;
  assign result.verdict   = out_verdict;
  assign result.valid_res = out_valid_res;
  assign stat.out_busy    = out_valid && !result.ready;

endmodule

`default_nettype wire

// ----- hdl/card_number_luhn_validator.sv -----
// Top level of the card number Luhn validator.
// Joins luhn_ctrl and luhn_dp; uses luhn_pkg and the channel interfaces.
//
// Usage: a card number arrives as one word on the card channel and one
// verdict word leaves on the result channel for each of them. The cfg
// channel writes the digit count limits (index 0 lower, index 1 upper),
// is always ready and is to be written by the user while no number is
// in flight; the block does not enforce it. A number passes through
// the shift-and-adjust steps of the binary to decimal converter, one
// per input bit, the digit scanner, one step per decimal digit, the
// result register load and the idle state that takes the next word.
// A new number is accepted while an earlier result still waits in the
// result register; if the receiver stalls longer, the verdict waits in
// the datapath while the controller holds in its done state until the
// register frees. Reset restores the limits to 13 and 16 and empties
// the result register.
`default_nettype none

module card_number_luhn_validator import luhn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  luhn_in_if.sink    card,
  luhn_out_if.source result,
  luhn_cfg_if.sink   cfg
);

  cmd_t  cmd;
  stat_t stat;

  luhn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (card.valid),
    .in_ready (card.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  luhn_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .card_number (card.card_number),
    .cfg         (cfg),
    .result      (result),
    .stat        (stat)
  );

endmodule

`default_nettype wire

// ----- hdl/luhn_chk.sv -----
// Port-level checker for the card number Luhn validator.
// Bound to card_number_luhn_validator; uses luhn_pkg for the verdict codes.
`default_nettype none

module luhn_chk import luhn_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_valid_res,
  input wire logic [1:0] out_verdict
);

  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_valid_res == (out_verdict == VerdictOk)))
    else $error("valid_res disagrees with verdict");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while a number is in flight");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_verdict)))
    else $error("stalled result word changed");

endmodule

bind card_number_luhn_validator luhn_chk u_luhn_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (card.valid),
  .in_ready      (card.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_valid_res (result.valid_res),
  .out_verdict   (result.verdict)
);

`default_nettype wire
